// ===== src/tkg_pkg.sv =====
// Shared types, constants and a helper function for the Trivium keystream generator.
`timescale 1ns / 1ps

package tkg_pkg;

	// Cipher geometry.
	localparam int STATE_W     = 288;
	localparam int KEY_LOW_W   = 64;
	localparam int KEY_HIGH_W  = 16;
	localparam int IV_LOW_W    = 64;
	localparam int IV_HIGH_W   = 16;
	localparam int IV_BASE     = 93;
	localparam int PERIOD_W    = 31;
	localparam int COUNT_W     = 32;
	localparam int OUT_W       = 64;

	// Rounds and output limits.
	localparam int INIT_ROUNDS  = 1152;
	localparam int MAX_OUT_BITS = 64;
	localparam int DIGIT_BITS   = 8;
	localparam int DIGIT_SHIFT  = $clog2(DIGIT_BITS);
	localparam int INIT_CYCLES  = INIT_ROUNDS / DIGIT_BITS;
	localparam int REQ_MAX      = DIGIT_BITS << 3;
	localparam int NBITS_W      = $clog2(REQ_MAX + 1);
	localparam int CYC_W        = $clog2(INIT_CYCLES);

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1048576);
	localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;

	// Opcodes of an input word.
	localparam logic [1:0] OP_GENERATE = 2'd0;
	localparam logic [1:0] OP_RESEED   = 2'd1;
	localparam logic [1:0] OP_CLEAR    = 2'd2;
	localparam logic [1:0] OP_UNUSED   = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_KEY_LOW  = 2'd0;
	localparam logic [1:0] REG_KEY_HIGH = 2'd1;
	localparam logic [1:0] REG_PERIOD   = 2'd2;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INIT,
		ST_GEN,
		ST_DONE
	} state_t;

	// Source of the result value when the output register loads.
	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_HOLD,
		SEL_SHIFT
	} out_sel_t;

	// Commands to the cipher core.
	typedef struct packed {
		logic load;
		logic clear;
		logic step;
	} core_ctrl_t;

	// Commands to the result datapath.
	typedef struct packed {
		logic     val_clear;
		logic     val_shift;
		logic     out_load;
		out_sel_t out_sel;
		logic     out_reseeded;
	} dp_ctrl_t;

	// Number of keystream bits requested by a width code, limited to the maximum.
	function automatic logic [NBITS_W-1:0] out_bits(input logic [1:0] ws);
		logic [NBITS_W-1:0] n;
		n = NBITS_W'(DIGIT_BITS) << ws;
		if (n > NBITS_W'(MAX_OUT_BITS)) begin
			n = NBITS_W'(MAX_OUT_BITS);
		end
		return n;
	endfunction

endpackage

// ===== src/tkg_core.sv =====
// Trivium state register that advances eight rounds per cycle when stepped.
`timescale 1ns / 1ps

module tkg_core
	import tkg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  core_ctrl_t            ctrl,
	input  logic [KEY_LOW_W-1:0]  key_low,
	input  logic [KEY_HIGH_W-1:0] key_high,
	input  logic [IV_LOW_W-1:0]   iv_low,
	input  logic [IV_HIGH_W-1:0]  iv_high,
	output logic [DIGIT_BITS-1:0] digit
);

	logic [STATE_W-1:0]    state_q;
	logic [STATE_W-1:0]    seed_state;
	logic [STATE_W-1:0]    rnd_state;
	logic [DIGIT_BITS-1:0] rnd_digit;
	logic                  t_a;
	logic                  t_b;
	logic                  t_c;

	// Initial state: key in s1..s80, IV in s94..s173, ones in s286..s288.
	always_comb begin
		seed_state = '0;
		seed_state[KEY_LOW_W-1:0] = key_low;
		seed_state[KEY_LOW_W +: KEY_HIGH_W] = key_high;
		seed_state[IV_BASE +: IV_LOW_W] = iv_low;
		seed_state[IV_BASE + IV_LOW_W +: IV_HIGH_W] = iv_high;
		seed_state[STATE_W-1 -: 3] = 3'b111;
	end

	// Eight Trivium rounds; the first keystream bit lands in the top of the digit.
	always_comb begin
		rnd_state = state_q;
		rnd_digit = '0;
		t_a = 1'b0;
		t_b = 1'b0;
		t_c = 1'b0;
		for (int k = 0; k < DIGIT_BITS; k++) begin
			t_a = rnd_state[65] ^ rnd_state[92];
			t_b = rnd_state[161] ^ rnd_state[176];
			t_c = rnd_state[242] ^ rnd_state[287];
			rnd_digit[DIGIT_BITS-1-k] = t_a ^ t_b ^ t_c;
			t_a = t_a ^ (rnd_state[90] & rnd_state[91]) ^ rnd_state[170];
			t_b = t_b ^ (rnd_state[174] & rnd_state[175]) ^ rnd_state[263];
			t_c = t_c ^ (rnd_state[285] & rnd_state[286]) ^ rnd_state[68];
			rnd_state = {rnd_state[STATE_W-2:0], 1'b0};
			rnd_state[0] = t_c;
			rnd_state[93] = t_a;
			rnd_state[177] = t_b;
		end
	end

	assign digit = rnd_digit;

	// State register: clear, load a fresh seed, or advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (ctrl.clear) begin
			state_q <= '0;
		end else if (ctrl.load) begin
			state_q <= seed_state;
		end else if (ctrl.step) begin
			state_q <= rnd_state;
		end
	end

endmodule

// ===== src/tkg_ctrl.sv =====
// Sequencer for requests, blank rounds, digit count and the keystream bit counter.
`timescale 1ns / 1ps

module tkg_ctrl
	import tkg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          opcode,
	input  logic [1:0]          width_select,
	output logic                out_valid,
	input  logic                out_stall,
	input  logic [PERIOD_W-1:0] reseed_period,
	output core_ctrl_t          core_ctrl,
	output dp_ctrl_t            dp_ctrl
);

	state_t             state_q;
	state_t             state_d;
	logic [1:0]         op_q;
	logic [1:0]         ws_q;
	logic [CYC_W-1:0]   cyc_q;
	logic [COUNT_W-1:0] count_q;
	logic               seeded_q;
	logic               reseeded_q;
	logic               out_valid_q;

	logic               accept;
	logic               need_seed;
	logic               seed_now;
	logic               init_last;
	logic               gen_last;
	logic               out_free;
	logic               finish;
	logic [CYC_W-1:0]   gen_last_idx;
	logic [COUNT_W:0]   count_sum;

	// Decode of the current word and progress.
	assign accept       = in_valid && (state_q == ST_IDLE);
	assign in_stall     = (state_q != ST_IDLE);
	assign need_seed    = !seeded_q || (count_q >= {1'b0, reseed_period});
	assign seed_now     = (opcode == OP_RESEED) || ((opcode == OP_GENERATE) && need_seed);
	assign init_last    = (cyc_q == CYC_W'(INIT_CYCLES - 1));
	assign gen_last_idx = CYC_W'((out_bits(ws_q) >> DIGIT_SHIFT) - 1'b1);
	assign gen_last     = (cyc_q == gen_last_idx);
	assign out_free     = !out_valid_q || !out_stall;
	assign count_sum    = {1'b0, count_q} + (COUNT_W + 1)'(out_bits(ws_q));
	assign out_valid    = out_valid_q;

	// A word is finished when its result is ready to be written out.
	always_comb begin
		case (state_q)
			ST_IDLE: finish = accept && (opcode == OP_CLEAR || opcode == OP_UNUSED);
			ST_INIT: finish = init_last && (op_q != OP_GENERATE);
			ST_GEN:  finish = gen_last;
			ST_DONE: finish = 1'b1;
			default: finish = 1'b0;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (seed_now) begin
						state_d = ST_INIT;
					end else if (opcode == OP_GENERATE) begin
						state_d = ST_GEN;
					end else if (!out_free) begin
						state_d = ST_DONE;
					end
				end
			end
			ST_INIT: begin
				if (init_last) begin
					if (op_q == OP_GENERATE) begin
						state_d = ST_GEN;
					end else begin
						state_d = out_free ? ST_IDLE : ST_DONE;
					end
				end
			end
			ST_GEN: begin
				if (gen_last) begin
					state_d = out_free ? ST_IDLE : ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands to the core and the result datapath.
	always_comb begin
		core_ctrl.load  = accept && seed_now;
		core_ctrl.clear = accept && (opcode == OP_CLEAR);
		core_ctrl.step  = (state_q == ST_INIT) || (state_q == ST_GEN);

		dp_ctrl.val_clear    = accept;
		dp_ctrl.val_shift    = (state_q == ST_GEN);
		dp_ctrl.out_load     = finish && out_free;
		dp_ctrl.out_reseeded = (state_q == ST_IDLE) ? 1'b0 : reseeded_q;
		case (state_q)
			ST_IDLE: dp_ctrl.out_sel = SEL_ZERO;
			ST_GEN:  dp_ctrl.out_sel = SEL_SHIFT;
			default: dp_ctrl.out_sel = SEL_HOLD;
		endcase
	end

	// State and word registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_UNUSED;
			ws_q        <= '0;
			cyc_q       <= '0;
			reseeded_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q       <= opcode;
				ws_q       <= width_select;
				reseeded_q <= seed_now;
			end
			if (accept || (state_q == ST_INIT && init_last)) begin
				cyc_q <= '0;
			end else if (state_q == ST_INIT || state_q == ST_GEN) begin
				cyc_q <= cyc_q + 1'b1;
			end
			if (dp_ctrl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Seeded flag and saturating count of keystream bits since the last seed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			seeded_q <= 1'b0;
		end else if (accept && (opcode == OP_CLEAR)) begin
			count_q  <= '0;
			seeded_q <= 1'b0;
		end else if (state_q == ST_INIT && init_last) begin
			count_q  <= '0;
			seeded_q <= 1'b1;
		end else if (state_q == ST_GEN && gen_last) begin
			count_q <= count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];
		end
	end

endmodule

// ===== src/trivium_keystream_generator_core.sv =====
// A generate word without reseed gives 8, 16, 32 or 64 bits from the generate state; the
// core advances eight rounds a cycle. A new word is accepted only when the sequencer is
// idle; a reseed adds 1152 blank rounds before generation, a force reseed runs only the
// blank rounds, and clear or unused words finish at acceptance unless the output is stalled.
// Reset: asynchronous, clears the state, counter, seeded flag and key; period is 1048576.
`timescale 1ns / 1ps

module trivium_keystream_generator_core
	import tkg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [KEY_LOW_W-1:0]  cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            opcode,
	input  logic [IV_LOW_W-1:0]   iv_low,
	input  logic [IV_HIGH_W-1:0]  iv_high,
	input  logic [1:0]            width_select,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [OUT_W-1:0]      random_value,
	output logic                  reseeded
);

	logic [KEY_LOW_W-1:0]  key_low_q;
	logic [KEY_HIGH_W-1:0] key_high_q;
	logic [PERIOD_W-1:0]   period_q;
	logic [OUT_W-1:0]      value_q;
	logic [OUT_W-1:0]      random_value_q;
	logic                  reseeded_q;
	logic [OUT_W-1:0]      value_next;
	logic [DIGIT_BITS-1:0] digit;
	core_ctrl_t            core_ctrl;
	dp_ctrl_t              dp_ctrl;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			period_q   <= PERIOD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				REG_KEY_HIGH: key_high_q <= cfg_data[KEY_HIGH_W-1:0];
				REG_PERIOD:   period_q   <= cfg_data[PERIOD_W-1:0];
				default:      ;
			endcase
		end
	end

	tkg_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.width_select  (width_select),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.reseed_period (period_q),
		.core_ctrl     (core_ctrl),
		.dp_ctrl       (dp_ctrl)
	);

	tkg_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (core_ctrl),
		.key_low  (key_low_q),
		.key_high (key_high_q),
		.iv_low   (iv_low),
		.iv_high  (iv_high),
		.digit    (digit)
	);

	// Keystream collects one digit a cycle while generating, earliest bits moving up.
	assign value_next = {value_q[OUT_W-DIGIT_BITS-1:0], digit};

	always_ff @(posedge clk) begin
		if (dp_ctrl.val_clear) begin
			value_q <= '0;
		end else if (dp_ctrl.val_shift) begin
			value_q <= value_next;
		end
	end

	// Output register, so the next word can start while a result waits.
	always_ff @(posedge clk) begin
		if (dp_ctrl.out_load) begin
			reseeded_q <= dp_ctrl.out_reseeded;
			case (dp_ctrl.out_sel)
				SEL_SHIFT: random_value_q <= value_next;
				SEL_HOLD:  random_value_q <= value_q;
				default:   random_value_q <= '0;
			endcase
		end
	end

	assign random_value = random_value_q;
	assign reseeded     = reseeded_q;

	// A waiting result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> !dp_ctrl.out_load)
		else $error("result overwritten while waiting");

	// The core receives at most one command per cycle.
	a_core_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({core_ctrl.load, core_ctrl.clear, core_ctrl.step}))
		else $error("conflicting core commands");

	// A force reseed keeps the block busy with blank rounds.
	a_reseed_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && opcode == OP_RESEED |=> in_stall)
		else $error("force reseed did not run blank rounds");

endmodule
